### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL. They compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/trpd_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared constants and codes of the pixel decoder and its palette memory.
// ----------------------------------------------------------------------------
`default_nettype none

package trpd_pkg;

  // Palette
  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned COLOR_W           = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Pixel field widths
  localparam int unsigned FRAME_W  = 24;
  localparam int unsigned PIXBUF_W = 32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPRESSED   = 2'd0,
    REG_PIXEL_FORMAT = 2'd1,
    REG_FRAME_PIXELS = 2'd2
  } cfg_reg_e;

  // Pixel formats; the unused code decodes as 32-bit BGRA
  typedef enum logic [1:0] {
    FMT_INDEX8 = 2'd0,
    FMT_BGR24  = 2'd1,
    FMT_BGRA32 = 2'd2
  } pix_fmt_e;

  // Request opcodes
  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } opcode_e;

endpackage

`default_nettype wire

### rtl/trpd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data. Read data holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module trpd_ram #(
  parameter int unsigned WIDTH = trpd_pkg::COLOR_W,
  parameter int unsigned DEPTH = trpd_pkg::PALETTE_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes the pixel-data byte stream of a TGA image (raw or RLE packets,
// 8-bit indexed, 24-bit BGR or 32-bit BGRA) into RGBA pixels with repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per cycle:
//   either a palette entry write or one byte of the pixel-data stream.
//   Output channel (out_valid_o / out_stall_i) carries one decoded pixel
//   with its repeat count, palette index and a frame-done mark.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is to be written only
//   while idle; the block does not enforce this. Throughput: one request
//   per cycle while in_stall_o is low. Each byte updates the packet and
//   frame counters as it is accepted; the palette read uses the registered
//   read port of the palette RAM. Path: a completed pixel is registered in
//   the decode stage, then in the output register with the palette color.
//   Stall: the output register holds while out_stall_i is high; the decode
//   stage can still take one more pixel, after which in_stall_o rises.
//   Reset: counters return to the start of a frame, registers to raw 32-bit
//   format with a one-pixel frame; palette entries read as zero until
//   written (per-entry valid bits, no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tga_rle_pixel_decoder #(
  parameter int unsigned PALETTE_DEPTH = trpd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration port
  input  wire logic                             cfg_we_i,
  input  wire logic [trpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [trpd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             opcode_i,
  input  wire logic [7:0]                       palette_slot_i,
  input  wire logic [trpd_pkg::COLOR_W-1:0]     palette_color_i,
  input  wire logic [7:0]                       data_byte_i,
  // Output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [7:0]                            red_o,
  output logic [7:0]                            green_o,
  output logic [7:0]                            blue_o,
  output logic [7:0]                            alpha_o,
  output logic [7:0]                            color_index_o,
  output logic [7:0]                            repeat_res_o,
  output logic                                  frame_done_o
);

  localparam int unsigned AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned FW  = trpd_pkg::FRAME_W;
  localparam int unsigned PBW = trpd_pkg::PIXBUF_W;

  // Configuration registers
  logic          compressed_q;
  logic [1:0]    pix_fmt_q;
  logic [FW-1:0] frame_pixels_q;

  // Decoder state
  logic           expect_header_q, expect_header_d;
  logic           run_packet_q, run_packet_d;
  logic [7:0]     packet_left_q, packet_left_d;
  logic [1:0]     byte_slot_q, byte_slot_d;
  logic [PBW-1:0] pixel_bytes_q, pixel_bytes_d;
  logic [FW-1:0]  pixels_done_q, pixels_done_d;

  // Palette valid bits
  logic [PALETTE_DEPTH-1:0] pal_valid_q;

  // Decode stage
  logic       s1_valid_q;
  logic [7:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic [7:0] s1_index_q, s1_repeat_q;
  logic       s1_done_q, s1_pal_q, s1_pal_ok_q;

  // Output register
  logic       s2_valid_q;
  logic [7:0] s2_red_q, s2_green_q, s2_blue_q, s2_alpha_q;
  logic [7:0] s2_index_q, s2_repeat_q;
  logic       s2_done_q;

  // Handshake
  logic in_acc, s1_move, pix_acc, pal_acc;

  assign s1_move    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && s2_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (opcode_i == trpd_pkg::OP_PIXEL);
  assign pal_acc    = in_acc && (opcode_i == trpd_pkg::OP_PALETTE);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q   <= 1'b0;
      pix_fmt_q      <= trpd_pkg::FMT_BGRA32;
      frame_pixels_q <= FW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trpd_pkg::REG_COMPRESSED:   compressed_q   <= cfg_wdata_i[0];
        trpd_pkg::REG_PIXEL_FORMAT: pix_fmt_q      <= cfg_wdata_i[1:0];
        trpd_pkg::REG_FRAME_PIXELS: frame_pixels_q <= cfg_wdata_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // Palette write and read
  logic            pal_slot_ok, pal_we;
  logic [AW-1:0]   pal_raddr;
  logic            pal_re;
  logic [trpd_pkg::COLOR_W-1:0] pal_rdata;

  assign pal_slot_ok = 32'(palette_slot_i) < PALETTE_DEPTH;
  assign pal_we      = pal_acc && pal_slot_ok;

  trpd_ram #(
    .WIDTH (trpd_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (palette_slot_i[AW-1:0]),
    .wdata_i (palette_color_i),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
    end else if (pal_we) begin
      pal_valid_q[palette_slot_i[AW-1:0]] <= 1'b1;
    end
  end

  // Byte assembly
  logic [PBW-1:0] new_bytes;
  logic [1:0]     slot_inc;
  logic [2:0]     bpp;
  logic           complete;
  logic [7:0]     pix_index;
  logic           idx_ok;

  always_comb begin
    case (byte_slot_q)
      2'd0:    new_bytes = pixel_bytes_q | {24'd0, data_byte_i};
      2'd1:    new_bytes = pixel_bytes_q | {16'd0, data_byte_i, 8'd0};
      2'd2:    new_bytes = pixel_bytes_q | {8'd0, data_byte_i, 16'd0};
      default: new_bytes = pixel_bytes_q | {data_byte_i, 24'd0};
    endcase
    case (pix_fmt_q)
      trpd_pkg::FMT_INDEX8: bpp = 3'd1;
      trpd_pkg::FMT_BGR24:  bpp = 3'd3;
      default:              bpp = 3'd4;
    endcase
  end

  assign slot_inc  = byte_slot_q + 2'd1;
  assign complete  = (slot_inc == 2'd0) || ({1'b0, slot_inc} >= bpp);
  assign pix_index = new_bytes[7:0];
  assign idx_ok    = 32'(pix_index) < PALETTE_DEPTH;
  assign pal_raddr = pix_index[AW-1:0];

  // Frame accounting
  logic [FW-1:0] total, remain;
  logic [7:0]    rep_pkt, rep_out;
  logic [7:0]    left_after;
  logic          res_gen, res_done;
  logic [7:0]    res_red, res_green, res_blue, res_alpha, res_index;
  logic          res_pal;

  assign total  = (frame_pixels_q == '0) ? FW'(1) : frame_pixels_q;
  assign remain = (pixels_done_q < total) ? (total - pixels_done_q) : FW'(1);

  // Decode one request
  always_comb begin
    expect_header_d = expect_header_q;
    run_packet_d    = run_packet_q;
    packet_left_d   = packet_left_q;
    byte_slot_d     = byte_slot_q;
    pixel_bytes_d   = pixel_bytes_q;
    pixels_done_d   = pixels_done_q;
    res_gen         = 1'b0;
    res_done        = 1'b0;
    pal_re          = 1'b0;
    rep_pkt         = 8'd1;
    rep_out         = 8'd1;
    left_after      = packet_left_q;
    res_pal         = 1'b0;
    res_index       = 8'd0;
    res_blue        = new_bytes[7:0];
    res_green       = new_bytes[15:8];
    res_red         = new_bytes[23:16];
    res_alpha       = trpd_pkg::ALPHA_OPAQUE;

    if (pix_acc) begin
      if (compressed_q && expect_header_q) begin
        // packet header
        run_packet_d    = data_byte_i[7];
        packet_left_d   = {1'b0, data_byte_i[6:0]} + 8'd1;
        expect_header_d = 1'b0;
        byte_slot_d     = 2'd0;
        pixel_bytes_d   = '0;
      end else begin
        pixel_bytes_d = new_bytes;
        byte_slot_d   = slot_inc;
        if (complete) begin
          byte_slot_d   = 2'd0;
          pixel_bytes_d = '0;
          res_gen       = 1'b1;

          // color fields
          case (pix_fmt_q)
            trpd_pkg::FMT_INDEX8: begin
              res_pal   = 1'b1;
              res_index = pix_index;
              pal_re    = idx_ok;
            end
            trpd_pkg::FMT_BGR24: ;
            default: res_alpha = new_bytes[31:24];
          endcase

          // packet progress
          if (compressed_q) begin
            if (run_packet_q) begin
              rep_pkt    = (packet_left_q != 8'd0) ? packet_left_q : 8'd1;
              left_after = 8'd0;
            end else if (packet_left_q != 8'd0) begin
              left_after = packet_left_q - 8'd1;
            end
            packet_left_d = left_after;
            if (left_after == 8'd0) begin
              expect_header_d = 1'b1;
            end
          end

          // clip against the frame end
          if (FW'(rep_pkt) >= remain) begin
            rep_out         = remain[7:0];
            res_done        = 1'b1;
            pixels_done_d   = '0;
            expect_header_d = 1'b1;
            packet_left_d   = 8'd0;
          end else begin
            rep_out       = rep_pkt;
            pixels_done_d = pixels_done_q + FW'(rep_pkt);
          end
        end
      end
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_header_q <= 1'b1;
      run_packet_q    <= 1'b0;
      packet_left_q   <= 8'd0;
      byte_slot_q     <= 2'd0;
      pixel_bytes_q   <= '0;
      pixels_done_q   <= '0;
    end else begin
      expect_header_q <= expect_header_d;
      run_packet_q    <= run_packet_d;
      packet_left_q   <= packet_left_d;
      byte_slot_q     <= byte_slot_d;
      pixel_bytes_q   <= pixel_bytes_d;
      pixels_done_q   <= pixels_done_d;
    end
  end

  // Decode stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (res_gen) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Decode stage payload
  always_ff @(posedge clk_i) begin
    if (res_gen) begin
      s1_red_q    <= res_red;
      s1_green_q  <= res_green;
      s1_blue_q   <= res_blue;
      s1_alpha_q  <= res_alpha;
      s1_index_q  <= res_index;
      s1_repeat_q <= rep_out;
      s1_done_q   <= res_done;
      s1_pal_q    <= res_pal;
      s1_pal_ok_q <= idx_ok && pal_valid_q[pal_raddr];
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_move) begin
      s2_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_q <= 1'b0;
    end
  end

  // Output register payload; palette color merged here
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      if (s1_pal_q) begin
        s2_blue_q  <= s1_pal_ok_q ? pal_rdata[7:0]   : 8'd0;
        s2_green_q <= s1_pal_ok_q ? pal_rdata[15:8]  : 8'd0;
        s2_red_q   <= s1_pal_ok_q ? pal_rdata[23:16] : 8'd0;
      end else begin
        s2_blue_q  <= s1_blue_q;
        s2_green_q <= s1_green_q;
        s2_red_q   <= s1_red_q;
      end
      s2_alpha_q  <= s1_alpha_q;
      s2_index_q  <= s1_index_q;
      s2_repeat_q <= s1_repeat_q;
      s2_done_q   <= s1_done_q;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign red_o         = s2_red_q;
  assign green_o       = s2_green_q;
  assign blue_o        = s2_blue_q;
  assign alpha_o       = s2_alpha_q;
  assign color_index_o = s2_index_q;
  assign repeat_res_o  = s2_repeat_q;
  assign frame_done_o  = s2_done_q;

  // Assertions
  `ASSERT_IMPL(a_repeat_nonzero, clk_i, rst_ni, s1_valid_q, s1_repeat_q != 8'd0)
  `ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, res_gen && res_done,
               pixels_done_q == '0 && expect_header_q)
  `ASSERT_NEXT(a_header_taken, clk_i, rst_ni, pix_acc && compressed_q && expect_header_q,
               !expect_header_q && byte_slot_q == 2'd0)
  `ASSERT_NEXT(a_no_overrun, clk_i, rst_ni, res_gen && !res_done, pixels_done_q < total)

endmodule

`default_nettype wire

### verif/trpd_pixel_checker.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder checker
// Follows the configuration writes and input requests of the decoder, models
// the packet, pixel and frame state to predict each decoded pixel, and
// compares every pixel taken from the output channel against the prediction.
// ----------------------------------------------------------------------------
module trpd_pixel_checker
  import trpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  opcode_i,
  input  logic [7:0]            palette_slot_i,
  input  logic [COLOR_W-1:0]    palette_color_i,
  input  logic [7:0]            data_byte_i,
  // Output channel
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            alpha_i,
  input  logic [7:0]            color_index_i,
  input  logic [7:0]            repeat_res_i,
  input  logic                  frame_done_i,
  // Status
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] color_index;
    logic [7:0] repeat_cnt;
    logic       frame_done;
  } pixel_t;

  // Modeled decoder state
  logic [COLOR_W-1:0]  palette_mem [PALETTE_DEPTH_DEF];
  logic                hdr_wait;
  logic                run_pkt;
  logic [7:0]          pkt_left;
  logic [1:0]          slot_idx;
  logic [PIXBUF_W-1:0] pix_buf;
  logic [FRAME_W-1:0]  frame_pos;

  // Modeled registers
  logic                rle_mode;
  logic [1:0]          fmt;
  logic [FRAME_W-1:0]  frame_len;

  pixel_t predicted_pixels[$];
  int     mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] pixel check: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic clear_model();
    for (int i = 0; i < PALETTE_DEPTH_DEF; i++) palette_mem[i] = '0;
    hdr_wait  = 1'b1;
    run_pkt   = 1'b0;
    pkt_left  = '0;
    slot_idx  = '0;
    pix_buf   = '0;
    frame_pos = '0;
    rle_mode  = 1'b0;
    fmt       = FMT_BGRA32;
    frame_len = FRAME_W'(1);
    predicted_pixels.delete();
  endtask

  // Advance the model by one accepted request; queue a pixel if one completes
  task automatic decode_request(input logic op, input logic [7:0] slot,
                                input logic [COLOR_W-1:0] color, input logic [7:0] b);
    int unsigned        nbytes;
    logic [COLOR_W-1:0] entry;
    logic [FRAME_W-1:0] total;
    logic [FRAME_W-1:0] remain;
    logic [7:0]         count;
    pixel_t             px;

    if (op == OP_PALETTE) begin
      if (slot < PALETTE_DEPTH_DEF) palette_mem[slot] = color;
      return;
    end

    // Packet header: run flag and pixel count
    if (rle_mode && hdr_wait) begin
      run_pkt  = b[7];
      pkt_left = {1'b0, b[6:0]} + 8'd1;
      hdr_wait = 1'b0;
      slot_idx = '0;
      pix_buf  = '0;
      return;
    end

    case (fmt)
      FMT_INDEX8: nbytes = 1;
      FMT_BGR24:  nbytes = 3;
      default:    nbytes = 4;
    endcase
    pix_buf  = pix_buf | (PIXBUF_W'(b) << (8 * slot_idx));
    slot_idx = slot_idx + 2'd1;
    if (slot_idx != 0 && slot_idx < nbytes) return;

    // Color of the completed pixel
    px.alpha       = ALPHA_OPAQUE;
    px.color_index = '0;
    if (fmt == FMT_INDEX8) begin
      px.color_index = pix_buf[7:0];
      entry = (pix_buf[7:0] < PALETTE_DEPTH_DEF) ? palette_mem[pix_buf[7:0]] : '0;
      px.blue  = entry[7:0];
      px.green = entry[15:8];
      px.red   = entry[23:16];
    end else begin
      px.blue  = pix_buf[7:0];
      px.green = pix_buf[15:8];
      px.red   = pix_buf[23:16];
      if (fmt != FMT_BGR24) px.alpha = pix_buf[31:24];
    end
    slot_idx = '0;
    pix_buf  = '0;

    // Packet bookkeeping
    count = 8'd1;
    if (rle_mode) begin
      if (run_pkt) begin
        count    = (pkt_left != 0) ? pkt_left : 8'd1;
        pkt_left = '0;
      end else if (pkt_left > 0) begin
        pkt_left = pkt_left - 8'd1;
      end
      if (pkt_left == 0) hdr_wait = 1'b1;
    end

    // Clip at the frame end
    total  = (frame_len != 0) ? frame_len : FRAME_W'(1);
    remain = (frame_pos < total) ? total - frame_pos : FRAME_W'(1);
    if (FRAME_W'(count) >= remain) begin
      count         = remain[7:0];
      px.frame_done = 1'b1;
      frame_pos     = '0;
      hdr_wait      = 1'b1;
      pkt_left      = '0;
    end else begin
      px.frame_done = 1'b0;
      frame_pos     = frame_pos + FRAME_W'(count);
    end
    px.repeat_cnt = count;
    predicted_pixels.push_back(px);
  endtask

  task automatic check_pixel();
    pixel_t want;

    if (predicted_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel with none expected, repeat 0x%0h", repeat_res_i));
      return;
    end
    want = predicted_pixels.pop_front();
    compare_field("red", red_i, want.red);
    compare_field("green", green_i, want.green);
    compare_field("blue", blue_i, want.blue);
    compare_field("alpha", alpha_i, want.alpha);
    compare_field("color_index", color_index_i, want.color_index);
    compare_field("repeat", repeat_res_i, want.repeat_cnt);
    compare_field("frame_done", 8'(frame_done_i), 8'(want.frame_done));
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COMPRESSED:   rle_mode  = cfg_wdata_i[0];
          REG_PIXEL_FORMAT: fmt       = cfg_wdata_i[1:0];
          REG_FRAME_PIXELS: frame_len = cfg_wdata_i[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        decode_request(opcode_i, palette_slot_i, palette_color_i, data_byte_i);
      if (out_valid_i && !out_stall_i) check_pixel();
      pending_o <= predicted_pixels.size();
    end
  end

endmodule

### verif/tb_tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Drives palette writes and pixel-data bytes into the decoder, first a short
// directed sequence over the formats, frame limits and packet corners, then
// random phases of RLE packets and raw pixels under varied configuration and
// sender/receiver idling. A checker module predicts and compares each pixel.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;
  import trpd_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 110;

  localparam logic [1:0]         FMT_UNUSED = 2'd3;
  localparam logic [FRAME_W-1:0] FRAME_MAX  = '1;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  opcode_i        = 1'b0;
  logic [7:0]            palette_slot_i  = '0;
  logic [COLOR_W-1:0]    palette_color_i = '0;
  logic [7:0]            data_byte_i     = '0;
  logic                  out_stall_i     = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] red_o, green_o, blue_o, alpha_o, color_index_o, repeat_res_o;
  logic       frame_done_o;

  int          pending;
  int          failures;
  int          quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  tga_rle_pixel_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .palette_slot_i (palette_slot_i),
    .palette_color_i(palette_color_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .color_index_o  (color_index_o),
    .repeat_res_o   (repeat_res_o),
    .frame_done_o   (frame_done_o)
  );

  trpd_pixel_checker u_scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .palette_slot_i (palette_slot_i),
    .palette_color_i(palette_color_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_i          (red_o),
    .green_i        (green_o),
    .blue_i         (blue_o),
    .alpha_i        (alpha_o),
    .color_index_i  (color_index_o),
    .repeat_res_i   (repeat_res_o),
    .frame_done_i   (frame_done_o),
    .pending_o      (pending),
    .fail_count_o   (failures)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request, with optional idle cycles ahead of it; returns on acceptance
  task automatic send_request(input opcode_e op, input logic [7:0] slot,
                              input logic [COLOR_W-1:0] color, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    palette_slot_i  <= slot;
    palette_color_i <= color;
    data_byte_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(OP_PIXEL, 8'($urandom()), COLOR_W'($urandom()), b);
  endtask

  task automatic send_palette(input logic [7:0] slot, input logic [COLOR_W-1:0] color);
    send_request(OP_PALETTE, slot, color, 8'($urandom()));
  endtask

  // Hold off the sender until every predicted pixel has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive cycles; only while idle
  task automatic configure(input logic comp, input logic [1:0] pfmt,
                           input logic [FRAME_W-1:0] frame);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_COMPRESSED;
    cfg_wdata_i <= CFG_DATA_W'(comp);
    @(posedge clk_i);
    cfg_idx_i   <= REG_PIXEL_FORMAT;
    cfg_wdata_i <= CFG_DATA_W'(pfmt);
    @(posedge clk_i);
    cfg_idx_i   <= REG_FRAME_PIXELS;
    cfg_wdata_i <= CFG_DATA_W'(frame);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random traffic: mostly well-formed packets or pixels, some palette writes
  // and stray bytes that knock the stream out of step
  task automatic run_phase(input int items, input logic comp, input logic [1:0] pfmt);
    int          sent;
    int          nb;
    int          body;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  hdr;

    sent = 0;
    case (pfmt)
      FMT_INDEX8: nb = 1;
      FMT_BGR24:  nb = 3;
      default:    nb = 4;
    endcase
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_palette(8'($urandom()), COLOR_W'($urandom()));
        sent++;
      end else if (pick < 15) begin
        send_byte(8'($urandom()));
        sent++;
      end else if (!comp) begin
        repeat (nb) send_byte(8'($urandom()));
        sent += nb;
      end else begin
        len = (pick < 18) ? $urandom_range(127) : $urandom_range(7);
        hdr = {1'($urandom_range(1)), 7'(len)};
        send_byte(hdr);
        body = hdr[7] ? nb : nb * (int'(len) + 1);
        repeat (body) send_byte(8'($urandom()));
        sent += body + 1;
      end
    end
  endtask

  initial begin
    logic                comp;
    logic [1:0]          pfmt;
    logic [FRAME_W-1:0]  frame;
    int                  mode;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: raw 32-bit, one-pixel frames; palette corners
    send_palette(8'd0, 24'hFFFFFF);
    send_palette(8'd255, 24'h00FF00);
    send_palette(8'h5A, 24'hA5C30F);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);

    // Indexed, frame size zero counts as one
    drain();
    configure(1'b0, FMT_INDEX8, '0);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(8'h5A);

    // Run clipped at the frame end, then a raw packet cut by a shrunk frame
    drain();
    configure(1'b1, FMT_INDEX8, FRAME_W'(5));
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
    configure(1'b1, FMT_INDEX8, FRAME_W'(1));
    send_byte(8'h5A);

    // Longest run in a maximal frame
    drain();
    configure(1'b1, FMT_BGR24, FRAME_MAX);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFE);

    // Unused format code decodes as 32-bit; then a format change mid-pixel
    drain();
    configure(1'b0, FMT_UNUSED, FRAME_W'(3));
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    send_byte(8'hC3);
    send_byte(8'h3C);
    drain();
    configure(1'b0, FMT_BGR24, FRAME_W'(3));
    send_byte(8'h99);

    // Random phases over every format, both stream kinds and idle patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      mode = (p + p / 4) % 4;
      case (mode)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 74; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      comp = (p >= RANDOM_PHASES / 2);
      pfmt = 2'(p);
      case (p)
        2:       frame = '0;
        5:       frame = FRAME_MAX;
        default: frame = FRAME_W'($urandom_range(1, 200));
      endcase
      configure(comp, pfmt, frame);
      run_phase(PHASE_ITEMS, comp, pfmt);
    end

    // Wait for the last pixels, then give the verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### tga_rle_pixel_decoder.f
+incdir+rtl
rtl/trpd_pkg.sv
rtl/trpd_ram.sv
rtl/tga_rle_pixel_decoder.sv
verif/trpd_pixel_checker.sv
verif/tb_tga_rle_pixel_decoder.sv
